// ===== src/lcdx_pkg.sv =====
`timescale 1ns / 1ps

package lcdx_pkg;

  localparam int QUEUE_DEPTH = 4;

  localparam int CMD_W = 2;
  localparam int VAL_W = 8;
  localparam int BYTE_W = 8;
  localparam int WAIT_W = 15;
  localparam int STEP_W = 5;
  localparam int IN_TDATA_W = 16;
  localparam int OUT_TDATA_W = 24;

  localparam logic [CMD_W-1:0] CMD_INIT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_INSTR = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CHAR = 2'd2;
  localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;

  localparam logic [BYTE_W-1:0] BACKLIGHT_BIT = 8'h80;
  localparam logic [BYTE_W-1:0] SEL_NORMAL = 8'h40;
  localparam logic [BYTE_W-1:0] EN_NORMAL = 8'h10;

  localparam logic [WAIT_W-1:0] WAIT_CLEAR = 15'd10000;

  localparam int WAKE_LEN = 9;
  localparam int BEATS_PER_BYTE = 4;
  localparam int SETUP_COUNT = 4;
  localparam int INIT_LEN = WAKE_LEN + BEATS_PER_BYTE * SETUP_COUNT;
  // last beat of the clear instruction
  localparam int CLEAR_STEP = WAKE_LEN + BEATS_PER_BYTE * 2 + BEATS_PER_BYTE - 1;

  localparam logic [0:0] REG_BACKLIGHT = 1'b0;
  localparam logic [0:0] REG_REVERSE = 1'b1;

  typedef struct packed {
    logic             is_init;
    logic             is_char;
    logic [VAL_W-1:0] value;
  } lcdx_entry_t;

  typedef struct packed {
    logic        valid;
    lcdx_entry_t entry;
  } lcdx_head_t;

  typedef struct packed {
    logic              en;
    logic [3:0]        nibble;
    logic [WAIT_W-1:0] wait_us;
  } lcdx_wake_t;

  function automatic lcdx_wake_t wake_beat(input logic [3:0] step);
    lcdx_wake_t w;
    w = '{en: 1'b0, nibble: 4'h0, wait_us: 15'd0};
    case (step)
      4'd0: w = '{en: 1'b0, nibble: 4'h0, wait_us: 15'd20000};
      4'd1: w = '{en: 1'b1, nibble: 4'h3, wait_us: 15'd10};
      4'd2: w = '{en: 1'b0, nibble: 4'h3, wait_us: 15'd15000};
      4'd3: w = '{en: 1'b1, nibble: 4'h3, wait_us: 15'd10};
      4'd4: w = '{en: 1'b0, nibble: 4'h3, wait_us: 15'd5000};
      4'd5: w = '{en: 1'b1, nibble: 4'h3, wait_us: 15'd10};
      4'd6: w = '{en: 1'b0, nibble: 4'h3, wait_us: 15'd5000};
      4'd7: w = '{en: 1'b1, nibble: 4'h2, wait_us: 15'd10};
      4'd8: w = '{en: 1'b0, nibble: 4'h2, wait_us: 15'd5000};
      default: w = '{en: 1'b0, nibble: 4'h0, wait_us: 15'd0};
    endcase
    return w;
  endfunction

  function automatic logic [BYTE_W-1:0] setup_instr(input logic [1:0] idx);
    logic [BYTE_W-1:0] b;
    case (idx)
      2'd0: b = 8'h28;
      2'd1: b = 8'h0F;
      2'd2: b = 8'h01;
      2'd3: b = 8'h08;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// ===== src/lcdx_front.sv =====
`timescale 1ns / 1ps

module lcdx_front import lcdx_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_TDATA_W-1:0] in_tdata,
  output lcdx_head_t            head,
  input  logic                  pop
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  lcdx_entry_t mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  logic [CMD_W-1:0] cmd;
  logic             push;
  logic             do_pop;
  lcdx_entry_t      entry;

  assign cmd = in_tdata[CMD_W-1:0];
  assign in_tready = (count_r != CNT_W'(DEPTH));
  // unused command code is taken and dropped
  assign push = in_tvalid && in_tready && (cmd != CMD_NONE);
  assign do_pop = pop && (count_r != '0);

  always_comb begin
    entry.is_init = (cmd == CMD_INIT);
    entry.is_char = (cmd == CMD_CHAR);
    entry.value = in_tdata[CMD_W +: VAL_W];
  end

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= entry;
    end
  end

  assign head.valid = (count_r != '0);
  assign head.entry = mem_r[rd_ptr_r];

endmodule

// ===== src/lcdx_back.sv =====
`timescale 1ns / 1ps

module lcdx_back import lcdx_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  lcdx_head_t             head,
  output logic                   pop,
  input  logic                   backlight_on,
  input  logic                   reverse_pins,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tlast
);

  logic [STEP_W-1:0] step_r, step_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0] port_r;
  logic [WAIT_W-1:0] wait_r;
  logic              last_r;

  logic              advance;
  logic [STEP_W-1:0] init_off;
  logic [1:0]        sub;
  logic [BYTE_W-1:0] src_byte;
  logic [3:0]        nib;
  logic [BYTE_W-1:0] en_bit;
  logic [BYTE_W-1:0] sel_bit;
  logic [BYTE_W-1:0] base;
  lcdx_wake_t        wake;
  logic [BYTE_W-1:0] beat_port;
  logic [WAIT_W-1:0] beat_wait;
  logic              beat_last;
  logic              in_wake;

  assign advance = head.valid && (!out_valid_r || out_tready);
  assign pop = advance && beat_last;

  assign en_bit = reverse_pins ? SEL_NORMAL : EN_NORMAL;
  assign sel_bit = reverse_pins ? EN_NORMAL : SEL_NORMAL;

  assign init_off = step_r - STEP_W'(WAKE_LEN);
  assign in_wake = head.entry.is_init && (step_r < STEP_W'(WAKE_LEN));

  always_comb begin
    wake = wake_beat(step_r[3:0]);
    if (head.entry.is_init) begin
      src_byte = setup_instr(init_off[3:2]);
      sub = init_off[1:0];
    end else begin
      src_byte = head.entry.value;
      sub = step_r[1:0];
    end
    nib = sub[1] ? src_byte[3:0] : src_byte[7:4];
    base = (backlight_on ? BACKLIGHT_BIT : '0) | (head.entry.is_char ? sel_bit : '0);
    if (in_wake) begin
      beat_port = (wake.en ? en_bit : '0) | {4'h0, wake.nibble};
      beat_wait = wake.wait_us;
    end else begin
      beat_port = base | {4'h0, nib} | (!sub[0] ? en_bit : '0);
      beat_wait = (head.entry.is_init && step_r == STEP_W'(CLEAR_STEP)) ? WAIT_CLEAR : '0;
    end
    beat_last = head.entry.is_init ? (step_r == STEP_W'(INIT_LEN - 1))
                                   : (step_r == STEP_W'(BEATS_PER_BYTE - 1));
  end

  always_comb begin
    step_nxt = step_r;
    out_valid_nxt = out_valid_r;
    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (advance) begin
      out_valid_nxt = 1'b1;
      step_nxt = beat_last ? '0 : step_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      step_r <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      port_r <= beat_port;
      wait_r <= beat_wait;
      last_r <= beat_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata = {1'b0, wait_r, port_r};
  assign out_tlast = last_r;

endmodule

// ===== src/lcd_4bit_expander_sequencer.sv =====
`timescale 1ns / 1ps
// the first port byte of a request passes through the request queue, then the output register
// throughput: one port byte per cycle while a request is queued and out_tready is high;
//   an instruction or character causes 4 port bytes, an initialize causes 25
// a request queue of DEPTH entries (default QUEUE_DEPTH) keeps intake going while bytes are sent
// reset: synchronous active low, clears queue, sequencer and both registers

module lcd_4bit_expander_sequencer import lcdx_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // command[1:0], value[9:2], zero fill
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // port_byte[7:0], wait_after_us[22:8], zero fill
  output logic                   out_tlast,
  input  logic                   cfg_psel,
  input  logic                   cfg_penable,
  input  logic                   cfg_pwrite,
  input  logic [2:0]             cfg_paddr,
  input  logic [31:0]            cfg_pwdata,
  output logic [31:0]            cfg_prdata,
  output logic                   cfg_pready
);

  logic       backlight_r;
  logic       reverse_r;
  logic       cfg_wr;
  lcdx_head_t head;
  logic       pop;

  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      backlight_r <= 1'b0;
      reverse_r <= 1'b0;
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == REG_BACKLIGHT) begin
        backlight_r <= cfg_pwdata[0];
      end else begin
        reverse_r <= cfg_pwdata[0];
      end
    end
  end

  assign cfg_prdata = {31'b0, (cfg_paddr[2] == REG_REVERSE) ? reverse_r : backlight_r};

  lcdx_front #(.DEPTH(DEPTH)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .head      (head),
    .pop       (pop)
  );

  lcdx_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .head         (head),
    .pop          (pop),
    .backlight_on (backlight_r),
    .reverse_pins (reverse_r),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tlast    (out_tlast)
  );

endmodule

// ===== src/lcdx_checker.sv =====
`timescale 1ns / 1ps

module lcdx_checker import lcdx_pkg::*; (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic                   out_tlast,
  input logic                   cfg_pready
);

  // stalled item stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("output item dropped while stalled");

  // a waiting byte is never the final byte of a request
  a_wait_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[WAIT_W+BYTE_W-1:BYTE_W] != '0) |-> !out_tlast)
    else $error("final byte carries a wait");

  // reset empties the output stage
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_pready)
    else $error("config port not ready");

endmodule

bind lcd_4bit_expander_sequencer lcdx_checker u_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .cfg_pready (cfg_pready)
);
